// ===== hdl/audio_rate_repeat_fifo_top_macros.svh =====
// ----------------------------------------------------------------------------
// audio_rate_repeat_fifo_top_macros.svh
// Assertion helpers shared by the rate-repeat FIFO RTL.
// ----------------------------------------------------------------------------
`ifndef AUDIO_RATE_REPEAT_FIFO_TOP_MACROS_SVH
`define AUDIO_RATE_REPEAT_FIFO_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define ARFQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define ARFQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/arfq_pkg.sv =====
// ----------------------------------------------------------------------------
// arfq_pkg
// Shared types and constants of the rate-repeat frame FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

package arfq_pkg;

  localparam int SAMPLE_W    = 8;
  localparam int SCALE_SHIFT = 8;
  localparam int OUT_W       = 16;
  localparam int FRAME_W     = 2 * OUT_W;
  localparam int DEV_W       = 18;
  localparam int SRC_W       = 16;
  localparam int SUM_W       = DEV_W + 1;       // phase + device_rate
  localparam int COUNT_W     = 15;              // reported counts
  localparam int DIV_CNT_W   = $clog2(SUM_W);
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = DEV_W;

  localparam logic [DEV_W-1:0] DEV_RATE_RST = DEV_W'(48000);
  localparam logic [SRC_W-1:0] SRC_RATE_RST = SRC_W'(13379);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_RATE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_RATE = 2'd2;

  // item kinds
  localparam logic KIND_SUBMIT = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_WRITE,
    ST_RDWAIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quot;
    logic [SRC_W-1:0] rem;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== hdl/arfq_div.sv =====
// ----------------------------------------------------------------------------
// arfq_div
// Restoring divider, one quotient bit per cycle; done pulses in the cycle after
// the last step, together with the final quotient and remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module arfq_div
  import arfq_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [SUM_W-1:0] dividend_i,
  input  wire logic [SRC_W-1:0] divisor_i,
  output div_rsp_t              rsp_o
);

  localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(SUM_W - 1);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [SUM_W-1:0]     num_q, num_d;   // dividend shifting out, quotient in
  logic [SRC_W-1:0]     rem_q, rem_d;
  logic [SRC_W-1:0]     div_q, div_d;
  logic [SRC_W:0]       shifted;
  logic                 ge;

  always_comb begin
    shifted = {rem_q, num_q[SUM_W-1]};
    ge      = shifted >= {1'b0, div_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    num_d   = num_q;
    rem_d   = rem_q;
    div_d   = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? SRC_W'(shifted - {1'b0, div_q}) : shifted[SRC_W-1:0];
      num_d = {num_q[SUM_W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LAST_STEP) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign rsp_o = '{done: done_q, quot: num_q, rem: rem_q};

endmodule

`default_nettype wire

// ===== hdl/arfq_mem.sv =====
// ----------------------------------------------------------------------------
// arfq_mem
// Single-port frame store, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module arfq_mem
  import arfq_pkg::*;
#(
  parameter int DEPTH  = 16384,
  parameter int ADDR_W = 14
) (
  input  wire logic               clk_i,
  input  wire logic               we_i,
  input  wire logic               re_i,
  input  wire logic [ADDR_W-1:0]  addr_i,
  input  wire logic [FRAME_W-1:0] wdata_i,
  output logic [FRAME_W-1:0]      rdata_o
);

  logic [FRAME_W-1:0] store_q [DEPTH];
  logic [FRAME_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      store_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= store_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/audio_rate_repeat_fifo_top.sv =====
// Flow: a read goes through ST_RDWAIT (registered store read), ST_DONE and the
//   output register; a word that changes nothing skips to ST_DONE. A submit goes
//   through the 19-step divider, ST_DIV to take its result, one store write per
//   frame copy N in ST_WRITE, ST_DONE and the output register. One word in flight;
//   output stalls hold a finished word in ST_DONE. No clearing pass after reset;
//   queue, pointers, phase and rate registers are ready as soon as rst_ni rises.
// ----------------------------------------------------------------------------
// audio_rate_repeat_fifo_top
// Nearest-neighbor rate converter in front of a stereo frame FIFO. A submit
// widens an 8-bit sample pair, steps the phase by device_rate, divides by
// source_rate and writes the frame once per whole period. A read pops a frame
// or answers silence with frame_valid low.
// ----------------------------------------------------------------------------
`default_nettype none

module audio_rate_repeat_fifo_top
  import arfq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16384
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // configuration
  input  wire logic                       cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]      cfg_data_i,
  // input words
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic                       kind_i,
  input  wire logic signed [SAMPLE_W-1:0] right_sample_i,
  input  wire logic signed [SAMPLE_W-1:0] left_sample_i,
  input  wire logic                       last_in_batch_i,
  // result words
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic signed [OUT_W-1:0]         right_out_o,
  output logic signed [OUT_W-1:0]         left_out_o,
  output logic                            frame_valid_o,
  output logic [COUNT_W-1:0]              copies_written_o,
  output logic                            dropped_o,
  output logic [COUNT_W-1:0]              fill_level_o,
  output logic                            batch_end_o
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_C   = CNT_W'(QUEUE_DEPTH);

  // configuration registers
  logic             enable_q;
  logic [DEV_W-1:0] dev_rate_q;
  logic [SRC_W-1:0] src_rate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q   <= 1'b0;
      dev_rate_q <= DEV_RATE_RST;
      src_rate_q <= SRC_RATE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ENABLE:      enable_q   <= cfg_data_i[0];
        CFG_DEVICE_RATE: dev_rate_q <= cfg_data_i;
        CFG_SOURCE_RATE: src_rate_q <= cfg_data_i[SRC_W-1:0];
        default: ;       // unused index, ignored
      endcase
    end
  end

  // control state
  state_e           state_q, state_d;
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [DEV_W-1:0] phase_q, phase_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;       // copies still to write

  // word being worked on
  logic [FRAME_W-1:0]     frame_q, frame_d;
  logic signed [OUT_W-1:0] res_right_q, res_right_d;
  logic signed [OUT_W-1:0] res_left_q, res_left_d;
  logic                   res_valid_q, res_valid_d;
  logic [CNT_W-1:0]       res_copies_q, res_copies_d;
  logic                   res_drop_q, res_drop_d;
  logic                   res_last_q, res_last_d;

  // output register
  logic                    out_valid_q, out_valid_d;
  logic signed [OUT_W-1:0] out_right_q, out_left_q;
  logic                    out_frame_q, out_drop_q, out_last_q;
  logic [COUNT_W-1:0]      out_copies_q, out_fill_q;
  logic                    out_load;

  // divider and frame store hookup
  logic               div_start;
  logic [SUM_W-1:0]   div_dividend;
  div_rsp_t           div_rsp;
  logic               mem_we, mem_re;
  logic [PTR_W-1:0]   mem_addr;
  logic [FRAME_W-1:0] mem_rdata;

  logic             in_accept;
  logic [CNT_W-1:0] space;

  assign in_accept    = in_valid_i && !in_stall_o;
  assign in_stall_o   = (state_q != ST_IDLE);
  assign div_dividend = SUM_W'(phase_q) + SUM_W'(dev_rate_q);
  assign space        = DEPTH_C - fill_q;
  assign out_load     = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d      = state_q;
    wr_ptr_d     = wr_ptr_q;
    rd_ptr_d     = rd_ptr_q;
    fill_d       = fill_q;
    phase_d      = phase_q;
    cnt_d        = cnt_q;
    frame_d      = frame_q;
    res_right_d  = res_right_q;
    res_left_d   = res_left_q;
    res_valid_d  = res_valid_q;
    res_copies_d = res_copies_q;
    res_drop_d   = res_drop_q;
    res_last_d   = res_last_q;
    div_start    = 1'b0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_addr     = rd_ptr_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          frame_d      = {left_sample_i, {SCALE_SHIFT{1'b0}},
                          right_sample_i, {SCALE_SHIFT{1'b0}}};
          res_right_d  = '0;
          res_left_d   = '0;
          res_valid_d  = 1'b0;
          res_copies_d = '0;
          res_drop_d   = 1'b0;
          res_last_d   = last_in_batch_i;
          state_d      = ST_DONE;
          if (kind_i == KIND_SUBMIT) begin
            if (enable_q && (dev_rate_q != '0) && (src_rate_q != '0)) begin
              div_start = 1'b1;
              state_d   = ST_DIV;
            end
          end else if (enable_q && (fill_q != '0)) begin
            mem_re  = 1'b1;
            state_d = ST_RDWAIT;
          end
        end
      end

      ST_DIV: begin
        if (div_rsp.done) begin
          phase_d = DEV_W'(div_rsp.rem);
          if (div_rsp.quot > SUM_W'(space)) begin
            // queue overflow: keep what fits, flag the rest
            res_copies_d = space;
            res_drop_d   = 1'b1;
          end else begin
            res_copies_d = CNT_W'(div_rsp.quot);
          end
          cnt_d   = res_copies_d;
          state_d = (res_copies_d == '0) ? ST_DONE : ST_WRITE;
        end
      end

      ST_WRITE: begin
        mem_we   = 1'b1;
        mem_addr = wr_ptr_q;
        wr_ptr_d = (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + 1'b1;
        fill_d   = fill_q + 1'b1;
        cnt_d    = cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          state_d = ST_DONE;
        end
      end

      ST_RDWAIT: begin
        res_right_d = mem_rdata[OUT_W-1:0];
        res_left_d  = mem_rdata[FRAME_W-1:OUT_W];
        res_valid_d = 1'b1;
        rd_ptr_d    = (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + 1'b1;
        fill_d      = fill_q - 1'b1;
        state_d     = ST_DONE;
      end

      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      fill_q      <= '0;
      phase_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wr_ptr_q    <= wr_ptr_d;
      rd_ptr_q    <= rd_ptr_d;
      fill_q      <= fill_d;
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q      <= frame_d;
    res_right_q  <= res_right_d;
    res_left_q   <= res_left_d;
    res_valid_q  <= res_valid_d;
    res_copies_q <= res_copies_d;
    res_drop_q   <= res_drop_d;
    res_last_q   <= res_last_d;
    if (out_load) begin
      out_right_q  <= res_right_q;
      out_left_q   <= res_left_q;
      out_frame_q  <= res_valid_q;
      out_copies_q <= COUNT_W'(res_copies_q);
      out_drop_q   <= res_drop_q;
      out_fill_q   <= COUNT_W'(fill_q);
      out_last_q   <= res_last_q;
    end
  end

  arfq_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (src_rate_q),
    .rsp_o      (div_rsp)
  );

  arfq_mem #(
    .DEPTH  (QUEUE_DEPTH),
    .ADDR_W (PTR_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (frame_q),
    .rdata_o (mem_rdata)
  );

  assign out_valid_o      = out_valid_q;
  assign right_out_o      = out_right_q;
  assign left_out_o       = out_left_q;
  assign frame_valid_o    = out_frame_q;
  assign copies_written_o = out_copies_q;
  assign dropped_o        = out_drop_q;
  assign fill_level_o     = out_fill_q;
  assign batch_end_o      = out_last_q;

`include "audio_rate_repeat_fifo_top_macros.svh"

  `ARFQ_ASSERT_NOW(a_fill_bound, 1'b1, fill_q <= DEPTH_C, "fill count above depth")
  `ARFQ_ASSERT_NOW(a_write_room, mem_we, fill_q < DEPTH_C, "store write into full queue")
  `ARFQ_ASSERT_NOW(a_read_data, mem_re, fill_q != '0, "store read from empty queue")
  `ARFQ_ASSERT_NOW(a_write_count, state_q == ST_WRITE, cnt_q != '0, "write loop ran out")
  `ARFQ_ASSERT_NEXT(a_div_done, state_q == ST_DIV && div_rsp.done, state_q != ST_DIV,
    "division result not taken")

endmodule

`default_nettype wire

// ===== tb/audio_rate_repeat_fifo_checker.sv =====
// ----------------------------------------------------------------------------
// audio_rate_repeat_fifo_checker
// Watches the config port and both word channels of the rate-repeat FIFO. It
// keeps its own phase, frame queue and registers, predicts the result word of
// every accepted input word, and compares in order. Reports a mismatch count
// and the number of result words still awaited.
// ----------------------------------------------------------------------------
module audio_rate_repeat_fifo_checker
  import arfq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16384
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic                  kind_i,
  input  logic [SAMPLE_W-1:0]   right_sample_i,
  input  logic [SAMPLE_W-1:0]   left_sample_i,
  input  logic                  last_in_batch_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [OUT_W-1:0]      right_out_i,
  input  logic [OUT_W-1:0]      left_out_i,
  input  logic                  frame_valid_i,
  input  logic [COUNT_W-1:0]    copies_written_i,
  input  logic                  dropped_i,
  input  logic [COUNT_W-1:0]    fill_level_i,
  input  logic                  batch_end_i,
  output int                    error_count_o,
  output int                    pending_o
);

  typedef struct packed {
    logic [OUT_W-1:0]   right;
    logic [OUT_W-1:0]   left;
    logic               frame_valid;
    logic [COUNT_W-1:0] copies;
    logic               dropped;
    logic [COUNT_W-1:0] fill;
    logic               batch_end;
  } frame_result_t;

  frame_result_t      awaited_results[$];

  logic [FRAME_W-1:0] frame_mem [QUEUE_DEPTH];
  int unsigned        wr_ptr;
  int unsigned        rd_ptr;
  int unsigned        queued_frames;
  int unsigned        phase_acc;
  logic               enabled;
  logic [DEV_W-1:0]   device_rate;
  logic [SRC_W-1:0]   source_rate;

  // one input word through the converter: phase step, repeat writes, or a pop
  function automatic frame_result_t step_converter(logic kind, logic [SAMPLE_W-1:0] rs,
                                                   logic [SAMPLE_W-1:0] ls, logic last);
    frame_result_t      r;
    int unsigned        periods;
    int unsigned        room;
    int unsigned        n;
    logic [FRAME_W-1:0] frame;
    r = '0;
    r.batch_end = last;
    if (kind == KIND_SUBMIT) begin
      if (enabled && device_rate != '0 && source_rate != '0) begin
        phase_acc = phase_acc + device_rate;
        periods   = phase_acc / source_rate;
        phase_acc = phase_acc % source_rate;
        room      = QUEUE_DEPTH - queued_frames;
        n         = periods;
        if (n > room) begin
          n         = room;
          r.dropped = 1'b1;
        end
        frame = {ls, 8'h00, rs, 8'h00};
        for (int i = 0; i < n; i++) begin
          frame_mem[wr_ptr] = frame;
          wr_ptr = (wr_ptr + 1) % QUEUE_DEPTH;
        end
        queued_frames = queued_frames + n;
        r.copies = COUNT_W'(n);
      end
    end else if (enabled && queued_frames > 0) begin
      r.right       = frame_mem[rd_ptr][OUT_W-1:0];
      r.left        = frame_mem[rd_ptr][FRAME_W-1:OUT_W];
      r.frame_valid = 1'b1;
      rd_ptr        = (rd_ptr + 1) % QUEUE_DEPTH;
      queued_frames = queued_frames - 1;
    end
    r.fill = COUNT_W'(queued_frames);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    frame_result_t exp_r;
    frame_result_t got;
    if (!rst_ni) begin
      awaited_results.delete();
      wr_ptr        = 0;
      rd_ptr        = 0;
      queued_frames = 0;
      phase_acc     = 0;
      enabled       = 1'b0;
      device_rate   = DEV_RATE_RST;
      source_rate   = SRC_RATE_RST;
      error_count_o = 0;
      pending_o     = 0;
    end else begin
      // results first: a word leaving now belongs to an earlier input word
      if (out_valid_i && !out_stall_i) begin
        got.right       = right_out_i;
        got.left        = left_out_i;
        got.frame_valid = frame_valid_i;
        got.copies      = copies_written_i;
        got.dropped     = dropped_i;
        got.fill        = fill_level_i;
        got.batch_end   = batch_end_i;
        if (awaited_results.size() == 0) begin
          error_count_o++;
          if (error_count_o <= 10)
            $display("%0t: result word with nothing awaited: r=%0d l=%0d fv=%0b cw=%0d",
                     $time, $signed(got.right), $signed(got.left), got.frame_valid,
                     got.copies);
        end else begin
          exp_r = awaited_results.pop_front();
          if (got.right !== exp_r.right || got.left !== exp_r.left ||
              got.frame_valid !== exp_r.frame_valid || got.copies !== exp_r.copies ||
              got.dropped !== exp_r.dropped || got.fill !== exp_r.fill ||
              got.batch_end !== exp_r.batch_end) begin
            error_count_o++;
            // fields: right, left, frame_valid, copies, dropped, fill, batch_end
            if (error_count_o <= 10)
              $display("%0t: exp %0d %0d %0b %0d %0b %0d %0b, got %0d %0d %0b %0d %0b %0d %0b",
                       $time,
                       $signed(exp_r.right), $signed(exp_r.left), exp_r.frame_valid,
                       exp_r.copies, exp_r.dropped, exp_r.fill, exp_r.batch_end,
                       $signed(got.right), $signed(got.left), got.frame_valid,
                       got.copies, got.dropped, got.fill, got.batch_end);
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        awaited_results.push_back(step_converter(kind_i, right_sample_i, left_sample_i,
                                                 last_in_batch_i));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ENABLE:      enabled     = cfg_data_i[0];
          CFG_DEVICE_RATE: device_rate = cfg_data_i[DEV_W-1:0];
          CFG_SOURCE_RATE: source_rate = cfg_data_i[SRC_W-1:0];
          default: ;
        endcase
      end
      pending_o = awaited_results.size();
    end
  end

endmodule

// ===== tb/audio_rate_repeat_fifo_top_tb.sv =====
// ----------------------------------------------------------------------------
// audio_rate_repeat_fifo_top_tb
// Stimulus and verdict for the rate-repeat FIFO. A short directed run covers
// the disabled block, empty reads, zero rates, an unused register index and
// sample extremes; rate phases with random words follow, ending with the
// queue held full so copies are dropped. A checker beside the block predicts
// and compares every result word.
// ----------------------------------------------------------------------------
module audio_rate_repeat_fifo_top_tb;
  import arfq_pkg::*;

  localparam int DEPTH     = 16384;
  localparam int DRAIN_PAD = 40;         // cycles past the last result before a reg write
  localparam int TIMEOUT   = 5_000_000;  // time units, far above the slowest clean run
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;  // no register behind it

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic                  kind;
  logic [SAMPLE_W-1:0]   right_sample;
  logic [SAMPLE_W-1:0]   left_sample;
  logic                  last_in_batch;
  logic                  out_valid;
  logic                  out_stall;
  logic [OUT_W-1:0]      right_out;
  logic [OUT_W-1:0]      left_out;
  logic                  frame_valid;
  logic [COUNT_W-1:0]    copies_written;
  logic                  dropped;
  logic [COUNT_W-1:0]    fill_level;
  logic                  batch_end;
  int                    error_count;
  int                    pending;

  // idle odds per cycle, in percent; zeroed for one no-idle stretch
  int in_gap_pct    = 21;
  int out_stall_pct = 21;

  always #2 clk = ~clk;

  audio_rate_repeat_fifo_top #(.QUEUE_DEPTH(DEPTH)) dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .kind_i           (kind),
    .right_sample_i   (right_sample),
    .left_sample_i    (left_sample),
    .last_in_batch_i  (last_in_batch),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .right_out_o      (right_out),
    .left_out_o       (left_out),
    .frame_valid_o    (frame_valid),
    .copies_written_o (copies_written),
    .dropped_o        (dropped),
    .fill_level_o     (fill_level),
    .batch_end_o      (batch_end)
  );

  audio_rate_repeat_fifo_checker #(.QUEUE_DEPTH(DEPTH)) checker_i (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .kind_i           (kind),
    .right_sample_i   (right_sample),
    .left_sample_i    (left_sample),
    .last_in_batch_i  (last_in_batch),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .right_out_i      (right_out),
    .left_out_i       (left_out),
    .frame_valid_i    (frame_valid),
    .copies_written_i (copies_written),
    .dropped_i        (dropped),
    .fill_level_i     (fill_level),
    .batch_end_i      (batch_end),
    .error_count_o    (error_count),
    .pending_o        (pending)
  );

  // receiver backpressure, redrawn every cycle
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  // Offer one word. Called at a falling edge; returns at the falling edge
  // after the word was taken. Valid only drops inside a random gap, so a
  // back-to-back word never sees valid lowered and raised in one step.
  task automatic send_word(input logic k, input logic [SAMPLE_W-1:0] rs,
                           input logic [SAMPLE_W-1:0] ls, input logic last);
    while ($urandom_range(99) < in_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    kind          <= k;
    right_sample  <= rs;
    left_sample   <= ls;
    last_in_batch <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // held one cycle each; the caller drops the enable after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= d;
    @(negedge clk);
  endtask

  // sender holds off until every awaited result word is out, then some slack
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_PAD) @(negedge clk);
  endtask

  // new rate setting on an idle block, then n random words
  task automatic run_rate_phase(input logic en, input int unsigned dev,
                                input logic [CFG_DATA_W-1:0] src_data, input int n,
                                input int read_pct);
    drain_results();
    write_reg(CFG_ENABLE, CFG_DATA_W'(en));
    write_reg(CFG_DEVICE_RATE, CFG_DATA_W'(dev));
    write_reg(CFG_SOURCE_RATE, src_data);
    cfg_we <= 1'b0;
    repeat (n)
      send_word(($urandom_range(99) < read_pct) ? KIND_READ : KIND_SUBMIT,
                SAMPLE_W'($urandom), SAMPLE_W'($urandom), $urandom_range(7) == 0);
  endtask

  initial begin
    int unsigned src;
    int unsigned dev;
    int          pct;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = CFG_ENABLE;
    cfg_data      = '0;
    in_valid      = 1'b0;
    kind          = KIND_SUBMIT;
    right_sample  = '0;
    left_sample   = '0;
    last_in_batch = 1'b0;
    out_stall     = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // --- directed ---
    // straight out of reset the block is off: submit ignored, read is silence
    send_word(KIND_SUBMIT, 8'sd127, -8'sd128, 1'b1);
    send_word(KIND_READ, 8'h00, 8'h00, 1'b0);

    // enable only, reset rates 48000/13379 stay in force
    drain_results();
    write_reg(CFG_ENABLE, CFG_DATA_W'(1));
    cfg_we <= 1'b0;
    send_word(KIND_READ, 8'h55, 8'hAA, 1'b1);        // empty queue: underflow
    send_word(KIND_SUBMIT, 8'sd127, -8'sd128, 1'b0);
    send_word(KIND_SUBMIT, -8'sd128, 8'sd127, 1'b1);
    send_word(KIND_SUBMIT, 8'h00, 8'hFF, 1'b0);
    send_word(KIND_SUBMIT, 8'h01, 8'h00, 1'b1);
    repeat (4) send_word(KIND_READ, 8'hFF, 8'hFF, 1'b0);

    // zero device rate: submit must not move phase or queue
    drain_results();
    write_reg(CFG_DEVICE_RATE, '0);
    cfg_we <= 1'b0;
    send_word(KIND_SUBMIT, 8'h7F, 8'h7F, 1'b0);
    send_word(KIND_READ, 8'h00, 8'h00, 1'b1);

    // zero source rate, plus a write to the index with no register
    drain_results();
    write_reg(CFG_DEVICE_RATE, CFG_DATA_W'(48000));
    write_reg(CFG_SOURCE_RATE, '0);
    write_reg(CFG_UNUSED, '1);
    cfg_we <= 1'b0;
    send_word(KIND_SUBMIT, 8'h80, 8'h80, 1'b1);
    send_word(KIND_READ, 8'h00, 8'h00, 1'b0);

    // disabled with frames still queued: nothing pops
    drain_results();
    write_reg(CFG_ENABLE, '0);
    write_reg(CFG_SOURCE_RATE, CFG_DATA_W'(13379));
    cfg_we <= 1'b0;
    send_word(KIND_READ, 8'h00, 8'h00, 1'b0);
    send_word(KIND_SUBMIT, 8'h12, 8'h34, 1'b1);

    // --- random phases; read share tracks the copy rate so fill wanders ---
    run_rate_phase(1'b1, 48000, CFG_DATA_W'(44100), 300, 52);
    run_rate_phase(1'b1, 1, CFG_DATA_W'(65535), 100, 10);        // copies are rare
    run_rate_phase(1'b1, 192000, {2'b10, 16'd65535}, 250, 75);   // top data bits dropped

    for (int p = 0; p < 4; p++) begin
      src = $urandom_range(65535, 4000);
      dev = src * $urandom_range(300, 50) / 100;
      if (dev > 192000) dev = 192000;
      pct = dev * 100 / (dev + src) + $urandom_range(6) - 3;
      if (p == 0) begin
        // stretch with no idling on either side
        in_gap_pct    = 0;
        out_stall_pct = 0;
      end else begin
        in_gap_pct    = 21;
        out_stall_pct = 21;
      end
      run_rate_phase(1'b1, dev, CFG_DATA_W'(src), 150, pct);
    end
    in_gap_pct    = 21;
    out_stall_pct = 21;

    run_rate_phase(1'b0, 48000, CFG_DATA_W'(44100), 50, 50);     // block switched off

    // source rate 1 at full device rate: the first submit fills the queue,
    // later ones refill freed slots and flag the surplus as dropped
    run_rate_phase(1'b1, 192000, CFG_DATA_W'(1), 250, 50);
    run_rate_phase(1'b1, 1, CFG_DATA_W'(1), 100, 50);

    drain_results();
    if (error_count == 0)
      $display("audio_rate_repeat_fifo_top_tb passed");
    else
      $display("audio_rate_repeat_fifo_top_tb failed");
    $finish;
  end

  // watchdog for a hung handshake or a result that never comes
  initial begin
    #TIMEOUT;
    $display("audio_rate_repeat_fifo_top_tb failed");
    $finish;
  end

endmodule

// ===== audio_rate_repeat_fifo_top.f =====
+incdir+hdl
hdl/arfq_pkg.sv
hdl/arfq_div.sv
hdl/arfq_mem.sv
hdl/audio_rate_repeat_fifo_top.sv
tb/audio_rate_repeat_fifo_checker.sv
tb/audio_rate_repeat_fifo_top_tb.sv
